[sv/spi_tsr_pkg.sv]
package spi_tsr_pkg;

    localparam int SENSOR_COUNT_DEF = 4;
    localparam int FRAME_BITS_DEF   = 16;

    localparam int ID_W     = 8;
    localparam int SEL_W    = 4;
    localparam int TEMP_W   = 10;
    localparam int STATUS_W = 2;

    // input tdata: sensor_id, miso_bit, padded to whole bytes
    localparam int S_DATA_W = 16;
    // output tdata: sclk_level, select_n, temperature, status, busy_res
    localparam int M_DATA_W = 24;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_TICK  = 1'b1
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_BUSY    = 2'd2
    } status_t;

endpackage

[sv/spi_temp_sensor_reader_unit.sv]
// serial read master for up to SENSOR_COUNT temperature sensors
//
// input channel (s_axis): one item per transfer. tuser carries the request
// kind, start or tick; tdata carries the sensor number and the sampled data
// line level. a start selects a sensor, each tick advances one half bit of
// the frame (falling edge samples, rising edge completes the bit).
// result channel (m_axis): exactly one result per input item, giving the
// pin levels after that item, the status code and, on the tick that ends a
// frame, the temperature in quarter degrees with tuser high.
//
// the result is valid in the cycle after its input transfer; the state
// update and result formatting sit between the input handshake and the
// result register, so one item is accepted every cycle without a stall.
// when the receiver stalls, the held result blocks s_axis_tready until it
// is taken; no item is dropped.
// reset (aresetn low, synchronous) returns to idle: clock high, all selects
// released, no result pending.
module spi_temp_sensor_reader_unit #(
    parameter int SENSOR_COUNT = spi_tsr_pkg::SENSOR_COUNT_DEF,
    parameter int FRAME_BITS   = spi_tsr_pkg::FRAME_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] sensor_id, [8] miso_bit, rest zero
    input  logic [spi_tsr_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [0] req_type
    input  logic                              s_axis_tuser,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] sclk_level, [4:1] select_n, [14:5] temperature, [16:15] status,
    // [17] busy_res, rest zero
    output logic [spi_tsr_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // [0] done_res
    output logic                              m_axis_tuser
);
    import spi_tsr_pkg::*;

    localparam int SENS_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int BC_W   = $clog2(FRAME_BITS + 1);
    localparam int OUT_W  = 1 + SEL_W + TEMP_W + STATUS_W + 1;

    logic              active_reg, active_next;
    logic              phase_reg, phase_next;
    logic [BC_W-1:0]   bit_count_reg, bit_count_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [SENS_W-1:0] sensor_reg, sensor_next;

    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;
    logic              m_done_reg, m_done_next;

    logic              in_xfer;
    req_t              req;
    logic [ID_W-1:0]   sensor_id;
    logic              miso;
    logic              done;
    logic [TEMP_W-1:0] temp;
    status_t           status;
    logic [SEL_W-1:0]  select_n;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign req       = req_t'(s_axis_tuser);
    assign sensor_id = s_axis_tdata[ID_W-1:0];
    assign miso      = s_axis_tdata[ID_W];

    always_comb begin
        active_next    = active_reg;
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        sensor_next    = sensor_reg;
        done           = 1'b0;
        temp           = '0;
        status         = ST_OK;

        case (req)
            REQ_START: begin
                if (active_reg) begin
                    status = ST_BUSY;
                end else if (sensor_id == '0 || sensor_id > ID_W'(SENSOR_COUNT)) begin
                    status = ST_INVALID;
                end else begin
                    active_next    = 1'b1;
                    sensor_next    = SENS_W'(sensor_id - ID_W'(1));
                    phase_next     = 1'b1;
                    bit_count_next = '0;
                    shift_next     = '0;
                end
            end
            REQ_TICK: begin
                if (active_reg) begin
                    if (phase_reg) begin
                        // falling edge: sample msb first
                        phase_next     = 1'b0;
                        shift_next     = {shift_reg[FRAME_BITS-2:0], miso};
                        bit_count_next = bit_count_reg + BC_W'(1);
                    end else begin
                        phase_next = 1'b1;
                        if (bit_count_reg >= BC_W'(FRAME_BITS)) begin
                            temp           = shift_reg[FRAME_BITS-1 -: TEMP_W];
                            done           = 1'b1;
                            active_next    = 1'b0;
                            bit_count_next = '0;
                        end
                    end
                end
            end
            default: ;
        endcase

        // selects beyond the pin field stay released
        select_n = ~(SEL_W'(active_next) << sensor_next);

        m_data_next = {active_next, status, temp, select_n, phase_next};
        m_done_next = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            phase_reg     <= 1'b1;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            sensor_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (in_xfer) begin
                active_reg    <= active_next;
                phase_reg     <= phase_next;
                bit_count_reg <= bit_count_next;
                shift_reg     <= shift_next;
                sensor_reg    <= sensor_next;
                m_valid_reg   <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            m_data_reg <= m_data_next;
            m_done_reg <= m_done_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(M_DATA_W - OUT_W)'(0), m_data_reg};
    assign m_axis_tuser  = m_done_reg;

`ifndef SYNTHESIS
    // idle engine parks the serial clock high
    assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> phase_reg)
        else $error("serial clock not high while idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        bit_count_reg <= BC_W'(FRAME_BITS))
        else $error("bit counter past frame length");

    // a completed frame leaves the engine idle with the clock high
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_done_reg |-> !m_data_reg[OUT_W-1] && m_data_reg[0]
            && !active_reg)
        else $error("frame done but engine still busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_done_reg |-> m_data_reg[SEL_W+TEMP_W:SEL_W+1] == '0)
        else $error("temperature nonzero without done");

    // a stalled result holds while new input is refused
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_axis_tready |=> m_valid_reg && $stable(m_data_reg)
            && $stable(active_reg))
        else $error("result or state changed during stall");
`endif

endmodule
